@@ design/ip_transport_header_locator_assert.svh @@
// ----------------------------------------------------------------------------
// IP transport header locator assertion macros
// Concurrent assertion wrappers clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef IP_TRANSPORT_HEADER_LOCATOR_ASSERT_SVH
`define IP_TRANSPORT_HEADER_LOCATOR_ASSERT_SVH

// same-cycle implication
`define IPTL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// next-cycle implication
`define IPTL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/iptl_pkg.sv @@
// ----------------------------------------------------------------------------
// IP transport header locator package
// Shared constants and the end-of-packet record passed front to back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package iptl_pkg;
  localparam int MAX_COUNT_W = 24;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_IP_HDR = 3'd1;
  localparam logic [2:0] ST_SHORT     = 3'd2;
  localparam logic [2:0] ST_CHAIN     = 3'd3;
  localparam logic [2:0] ST_NO_PORTS  = 3'd4;

  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic [7:0] EXT_HOP    = 8'd0;
  localparam logic [7:0] EXT_ROUTE  = 8'd43;
  localparam logic [7:0] EXT_DEST   = 8'd60;
  localparam logic [7:0] EXT_MOBIL  = 8'd135;
  localparam logic [7:0] EXT_SHIM6  = 8'd140;
  localparam logic [7:0] EXT_AUTH   = 8'd51;

  typedef struct packed {
    logic [MAX_COUNT_W-1:0] size;
    logic [MAX_COUNT_W-1:0] hdr_offset;
    logic                   mode_v6;
    logic [5:0]             prefix;
    logic [3:0]             hdr_words;
    logic [15:0]            ip_length;
    logic [7:0]             proto;
  } pkt_rec_t;

  function automatic logic is_chain(input logic [7:0] t);
    return (t == EXT_HOP) || (t == EXT_ROUTE) || (t == EXT_DEST) ||
           (t == EXT_MOBIL) || (t == EXT_SHIM6) || (t == EXT_AUTH);
  endfunction
endpackage

@@ design/iptl_front.sv @@
// ----------------------------------------------------------------------------
// IP transport header locator front end
// Per-byte header capture and IPv6 extension chain walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module iptl_front #(
  parameter int COUNT_WIDTH = 17
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  input  logic              is_ipv6,
  input  logic [5:0]        prefix,
  output logic              push,
  output iptl_pkg::pkt_rec_t rec
);
  import iptl_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

  logic [COUNT_WIDTH-1:0] byte_count, byte_count_next;
  logic                   mode_v6, mode_v6_next;
  logic [15:0]            ip_length, ip_length_next;
  logic [3:0]             hdr_words, hdr_words_next;
  logic [7:0]             cur_type, cur_type_next;
  logic [7:0]             pend_type, pend_type_next;
  logic [COUNT_WIDTH-1:0] hdr_offset, hdr_offset_next;
  logic                   walk_done, walk_done_next;

  logic                   first;
  logic [COUNT_WIDTH-1:0] pre_w;
  logic [COUNT_WIDTH:0]   off_sum;
  logic [COUNT_WIDTH:0]   off_plus1;

  assign first = (byte_count == '0);
  assign pre_w = COUNT_WIDTH'(prefix);

  always_comb begin
    mode_v6_next    = first ? is_ipv6 : mode_v6;
    hdr_offset_next = first ? pre_w + COUNT_WIDTH'(40) : hdr_offset;
    walk_done_next  = first ? 1'b0 : walk_done;
    cur_type_next   = first ? 8'd0 : cur_type;
    pend_type_next  = first ? 8'd0 : pend_type;
    ip_length_next  = first ? 16'd0 : ip_length;
    hdr_words_next  = first ? 4'd0 : hdr_words;
    byte_count_next = byte_count;
    off_plus1 = {1'b0, hdr_offset_next} + (COUNT_WIDTH+1)'(1);
    off_sum   = {1'b0, hdr_offset_next} +
                ((cur_type_next == EXT_AUTH) ? (COUNT_WIDTH+1)'({data_byte, 2'b00})
                                             : (COUNT_WIDTH+1)'({data_byte, 3'b000})) +
                (COUNT_WIDTH+1)'(8);
    if (byte_count != CMAX) begin
      if (!mode_v6_next) begin
        if (byte_count == pre_w) begin
          hdr_words_next = data_byte[3:0];
        end else if (byte_count == pre_w + COUNT_WIDTH'(2)) begin
          ip_length_next[15:8] = data_byte;
        end else if (byte_count == pre_w + COUNT_WIDTH'(3)) begin
          ip_length_next[7:0] = data_byte;
        end else if (byte_count == pre_w + COUNT_WIDTH'(9)) begin
          cur_type_next = data_byte;
        end
      end else begin
        if (byte_count == pre_w + COUNT_WIDTH'(4)) begin
          ip_length_next[15:8] = data_byte;
        end else if (byte_count == pre_w + COUNT_WIDTH'(5)) begin
          ip_length_next[7:0] = data_byte;
        end else if (byte_count == pre_w + COUNT_WIDTH'(6)) begin
          cur_type_next  = data_byte;
          walk_done_next = !is_chain(data_byte);
        end else if (!walk_done_next && is_chain(cur_type_next)) begin
          if (byte_count == hdr_offset_next) begin
            pend_type_next = data_byte;
          end else if ({1'b0, byte_count} == off_plus1) begin
            hdr_offset_next = off_sum[COUNT_WIDTH] ? CMAX : off_sum[COUNT_WIDTH-1:0];
            cur_type_next   = pend_type_next;
            if (!is_chain(pend_type_next)) begin
              walk_done_next = 1'b1;
            end
          end
        end
      end
      byte_count_next = byte_count + COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      mode_v6    <= 1'b0;
      walk_done  <= 1'b0;
    end else if (accept) begin
      byte_count <= last_byte ? '0 : byte_count_next;
      mode_v6    <= last_byte ? 1'b0 : mode_v6_next;
      walk_done  <= last_byte ? 1'b0 : walk_done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ip_length  <= ip_length_next;
      hdr_words  <= hdr_words_next;
      cur_type   <= cur_type_next;
      pend_type  <= pend_type_next;
      hdr_offset <= hdr_offset_next;
    end
  end

  assign push = accept && last_byte;

  always_comb begin
    rec.size       = MAX_COUNT_W'(byte_count_next);
    rec.hdr_offset = MAX_COUNT_W'(hdr_offset_next);
    rec.mode_v6    = mode_v6_next;
    rec.prefix     = prefix;
    rec.hdr_words  = hdr_words_next;
    rec.ip_length  = ip_length_next;
    rec.proto      = cur_type_next;
  end
endmodule

@@ design/iptl_queue.sv @@
// ----------------------------------------------------------------------------
// IP transport header locator record queue
// Two-entry queue of end-of-packet records between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module iptl_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  iptl_pkg::pkt_rec_t push_rec,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output iptl_pkg::pkt_rec_t head
);
  import iptl_pkg::*;

  pkt_rec_t   slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

@@ design/iptl_back.sv @@
// ----------------------------------------------------------------------------
// IP transport header locator back end
// Length checks and result word, held in an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module iptl_back #(
  parameter int COUNT_WIDTH = 17
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rec_valid,
  input  iptl_pkg::pkt_rec_t rec,
  output logic               pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [31:0]        m_tdata
);
  import iptl_pkg::*;

  localparam int W = COUNT_WIDTH + 2;

  logic [W-1:0] size, pre, ipl, off4, off6, offset;
  logic [2:0]   status;
  logic [7:0]   proto;
  logic         ports;
  logic         tcp_udp;

  assign size = W'(rec.size[COUNT_WIDTH-1:0]);
  assign pre  = W'(rec.prefix);
  assign ipl  = W'(rec.ip_length);
  assign off4 = pre + W'({rec.hdr_words, 2'b00});
  assign off6 = W'(rec.hdr_offset[COUNT_WIDTH-1:0]);
  assign offset  = rec.mode_v6 ? off6 : off4;
  assign tcp_udp = (rec.proto == PROTO_TCP) || (rec.proto == PROTO_UDP);

  always_comb begin
    status = ST_OK;
    ports  = 1'b0;
    if (!rec.mode_v6) begin
      if (size < pre + W'(20)) begin
        status = ST_NO_IP_HDR;
      end else if (size < pre + ipl) begin
        status = ST_SHORT;
      end else if (tcp_udp) begin
        if (size < offset + W'(4)) status = ST_NO_PORTS;
        else ports = 1'b1;
      end
    end else begin
      if (size < pre + W'(40)) begin
        status = ST_NO_IP_HDR;
      end else if (size < pre + W'(40) + ipl) begin
        status = ST_SHORT;
      end else if (size < offset + W'(2)) begin
        status = ST_CHAIN;
      end else if (tcp_udp) begin
        if (size < offset + W'(4)) status = ST_NO_PORTS;
        else ports = 1'b1;
      end
    end
    proto = (status == ST_OK) ? rec.proto : 8'd0;
  end

  assign pop = rec_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= {3'b000, ports, (status == ST_OK) ? offset[16:0] : 17'd0, proto, status};
    end
  end
endmodule

@@ design/ip_transport_header_locator.sv @@
// ----------------------------------------------------------------------------
// IP transport header locator
// Finds the transport header of IPv4/IPv6 packets streamed a byte per word.
// ----------------------------------------------------------------------------
//  channel | dir | content
//  s_*     | in  | packet bytes, tlast ends packet, tuser = IPv6 on first byte
//  m_*     | out | one result word per packet
//  cfg_*   | in  | prefix_bytes write
//
//  One byte accepted per cycle while the queue is not full; the per-byte walk in the front end sets it.
//  After the last byte, the result passes through a two-entry queue and the output register.
//  s_tready drops only while the queue is full behind a stalled output.
//  Synchronous reset; prefix_bytes resets to 4.
`timescale 1ns / 1ps
module ip_transport_header_locator #(
  parameter int COUNT_WIDTH = 17
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,
  input  logic        s_tuser,   // [0] is_ipv6
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [2:0] status, [10:3] transport_protocol,
                                 // [27:11] transport_offset, [28] has_ports
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data   // [5:0] prefix_bytes
);
  import iptl_pkg::*;

  logic     [5:0] prefix;
  logic           push, full, pop, q_valid, accept;
  pkt_rec_t       push_rec, head;

  assign cfg_ready = 1'b1;
  assign s_tready  = !full;
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix <= 6'd4;
    end else if (cfg_valid) begin
      prefix <= cfg_data;
    end
  end

  iptl_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
    .clk, .rst, .accept,
    .data_byte(s_tdata), .last_byte(s_tlast), .is_ipv6(s_tuser),
    .prefix, .push, .rec(push_rec)
  );

  iptl_queue u_queue (
    .clk, .rst, .push, .push_rec, .full, .pop, .valid(q_valid), .head
  );

  iptl_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk, .rst, .rec_valid(q_valid), .rec(head), .pop,
    .m_tvalid, .m_tready, .m_tdata
  );
endmodule

@@ design/iptl_checker.sv @@
// ----------------------------------------------------------------------------
// IP transport header locator checker
// Port-level checks on result words and input ready, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ip_transport_header_locator_assert.svh"
module iptl_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);
  import iptl_pkg::*;

  logic [2:0] st;
  logic [7:0] pr;
  logic       pt;

  assign st = m_tdata[2:0];
  assign pr = m_tdata[10:3];
  assign pt = m_tdata[28];

  `IPTL_ASSERT(a_status_range, !m_tvalid || (st <= ST_NO_PORTS), "status out of range")
  `IPTL_ASSERT(a_err_zero, !m_tvalid || (st == ST_OK) || (m_tdata[28:3] == '0), "error not zero")
  `IPTL_ASSERT(a_ports_proto, !(m_tvalid && pt) || (pr == PROTO_TCP) || (pr == PROTO_UDP), "bad ports")
  `IPTL_ASSERT(a_ready_stall, s_tready || m_tvalid, "input stalled with no result waiting")
  `IPTL_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed")
endmodule

bind ip_transport_header_locator iptl_checker u_iptl_checker (.*);

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// IP transport header locator testbench
// Streams IPv4/IPv6 packets through the block and compares each result word
// with a cycle-free predictor of the header walk, under random input gaps and output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
  import iptl_pkg::*;

  localparam int CNT_W   = 17;
  localparam int CNT_MAX = (1 << CNT_W) - 1;
  localparam int WDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [5:0]  cfg_data = '0;

  int  n_errors = 0;
  bit  gaps_on = 1'b1;
  bit  stall_on = 1'b1;
  bit  hold_req = 1'b0;
  int  idle_cycles = 0;
  byte unsigned pkt[$];

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  proto;
    logic [16:0] offset;
    logic        ports;
  } loc_result_t;

  ip_transport_header_locator #(.COUNT_WIDTH(CNT_W)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tlast(s_tlast), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(input string what);
    n_errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  class locator_scoreboard;
    int prefix = 4;
    int count, v6, ip_len, hwords, cur_t, pend_t, hoff, done;
    loc_result_t pending_results[$];

    function bit ext_hdr(int t);
      return t == EXT_HOP || t == EXT_ROUTE || t == EXT_DEST || t == EXT_MOBIL ||
             t == EXT_SHIM6 || t == EXT_AUTH;
    endfunction

    function void clear();
      count = 0; v6 = 0; ip_len = 0; hwords = 0;
      cur_t = 0; pend_t = 0; hoff = 0; done = 0;
    endfunction

    function void note_byte(int b, bit last, bit is6);
      int p, size, st, pr, off, pt;
      loc_result_t r;
      p = count;
      if (p == 0) begin
        v6 = is6; hoff = prefix + 40; done = 0;
        cur_t = 0; pend_t = 0; ip_len = 0; hwords = 0;
      end
      if (p < CNT_MAX) begin
        if (v6 == 0) begin
          if (p == prefix) hwords = b & 15;
          else if (p == prefix + 2) ip_len = (ip_len & 'hff) | (b << 8);
          else if (p == prefix + 3) ip_len = (ip_len & 'hff00) | b;
          else if (p == prefix + 9) cur_t = b;
        end else begin
          if (p == prefix + 4) ip_len = (ip_len & 'hff) | (b << 8);
          else if (p == prefix + 5) ip_len = (ip_len & 'hff00) | b;
          else if (p == prefix + 6) begin
            cur_t = b;
            done = !ext_hdr(b);
          end else if (!done && ext_hdr(cur_t)) begin
            if (p == hoff) pend_t = b;
            else if (p == hoff + 1) begin
              hoff = hoff + b * ((cur_t == EXT_AUTH) ? 4 : 8) + 8;
              if (hoff > CNT_MAX) hoff = CNT_MAX;
              cur_t = pend_t;
              if (!ext_hdr(cur_t)) done = 1;
            end
          end
        end
        count = p + 1;
      end
      if (!last) return;
      size = count; st = ST_OK; pr = 0; pt = 0;
      if (v6 == 0) begin
        off = prefix + hwords * 4;
        if (size < prefix + 20) st = ST_NO_IP_HDR;
        else if (size < prefix + ip_len) st = ST_SHORT;
      end else begin
        off = hoff;
        if (size < prefix + 40) st = ST_NO_IP_HDR;
        else if (size < prefix + 40 + ip_len) st = ST_SHORT;
        else if (size < off + 2) st = ST_CHAIN;
      end
      if (st == ST_OK) begin
        pr = cur_t;
        if (pr == PROTO_TCP || pr == PROTO_UDP) begin
          if (size < off + 4) st = ST_NO_PORTS;
          else pt = 1;
        end
      end
      if (st != ST_OK) begin
        pr = 0; off = 0; pt = 0;
      end
      r.status = 3'(st); r.proto = 8'(pr); r.offset = 17'(off); r.ports = 1'(pt);
      pending_results.push_back(r);
      clear();
    endfunction

    task check_word(logic [31:0] w);
      loc_result_t e;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result word %h", w));
        return;
      end
      e = pending_results.pop_front();
      if (w[2:0] !== e.status)
        report($sformatf("status %0d, want %0d", w[2:0], e.status));
      if (w[10:3] !== e.proto)
        report($sformatf("protocol %0d, want %0d", w[10:3], e.proto));
      if (w[27:11] !== e.offset)
        report($sformatf("offset %0d, want %0d", w[27:11], e.offset));
      if (w[28] !== e.ports)
        report($sformatf("has_ports %0b, want %0b", w[28], e.ports));
    endtask
  endclass

  locator_scoreboard sb = new();

  // result checking and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_word(m_tdata);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // receiver: random stalls, long holds on request
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else if (stall_on && $urandom_range(0, 99) < 2) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(15, 60)) @(posedge clk);
      end else begin
        m_tready <= stall_on ? ($urandom_range(0, 99) < 70) : 1'b1;
      end
    end
  end

  function automatic int rand_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(input byte unsigned b, input bit last, input bit user);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    s_tuser  <= user;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_byte(b, last, user);
    gap = rand_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_packet(input bit is6);
    for (int i = 0; i < pkt.size(); i++)
      send_word(pkt[i], i == pkt.size() - 1, (i == 0) ? is6 : 1'($urandom));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_prefix(input int v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= 6'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.prefix = v;
  endtask

  function automatic void add_rand(int n);
    repeat (n) pkt.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void trim(int cut);
    while (cut > 0 && pkt.size() > 1) begin
      void'(pkt.pop_back());
      cut--;
    end
  endfunction

  function automatic void build_v4(int ihl, int proto, int payload, int len_adj, int cut);
    int base, hlen, tot;
    pkt.delete();
    add_rand(sb.prefix);
    base = pkt.size();
    hlen = ihl * 4;
    add_rand(hlen < 20 ? 20 : hlen);
    add_rand(payload);
    tot = pkt.size() - base + len_adj;
    pkt[base]     = {4'h4, 4'(ihl)};
    pkt[base + 2] = 8'(tot >> 8);
    pkt[base + 3] = 8'(tot);
    pkt[base + 9] = 8'(proto);
    trim(cut);
  endfunction

  function automatic void build_v6(int chain[$], int proto, int payload, int len_adj, int cut);
    int base, hl, nxt, tot;
    pkt.delete();
    add_rand(sb.prefix);
    base = pkt.size();
    add_rand(40);
    pkt[base + 6] = 8'((chain.size() > 0) ? chain[0] : proto);
    foreach (chain[i]) begin
      nxt = (i + 1 < chain.size()) ? chain[i + 1] : proto;
      hl = $urandom_range(0, 2);
      pkt.push_back(8'(nxt));
      pkt.push_back(8'(hl));
      add_rand(((chain[i] == EXT_AUTH) ? hl * 4 : hl * 8) + 6);
    end
    add_rand(payload);
    tot = pkt.size() - base - 40 + len_adj;
    pkt[base + 4] = 8'(tot >> 8);
    pkt[base + 5] = 8'(tot);
    trim(cut);
  endfunction

  function automatic int rand_ext();
    int kinds[6] = '{EXT_HOP, EXT_ROUTE, EXT_DEST, EXT_MOBIL, EXT_SHIM6, EXT_AUTH};
    return kinds[$urandom_range(0, 5)];
  endfunction

  function automatic int rand_proto();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return PROTO_TCP;
    if (r < 7) return PROTO_UDP;
    if (r < 8) return 44;
    return $urandom_range(0, 255);
  endfunction

  task automatic random_packet();
    int kind, chain[$];
    bit is6;
    kind = $urandom_range(0, 99);
    is6 = 1'($urandom_range(0, 1));
    chain.delete();
    if (kind < 85) begin
      // well-formed, occasionally clipped or with a wrong length
      if (is6) begin
        repeat ($urandom_range(0, 4)) chain.push_back(rand_ext());
        build_v6(chain, rand_proto(), $urandom_range(0, 12),
                 ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8) : 0,
                 ($urandom_range(0, 7) == 0) ? $urandom_range(1, 20) : 0);
      end else begin
        build_v4(($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(5, 8),
                 rand_proto(), $urandom_range(0, 12),
                 ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8) : 0,
                 ($urandom_range(0, 7) == 0) ? $urandom_range(1, 20) : 0);
      end
    end else begin
      pkt.delete();
      add_rand($urandom_range(1, 80));
    end
    send_packet(is6);
  endtask

  task automatic directed();
    int all_ext[$], ch[$];
    all_ext = '{EXT_HOP, EXT_ROUTE, EXT_DEST, EXT_MOBIL, EXT_SHIM6, EXT_AUTH};
    build_v4(5, PROTO_TCP, 8, 0, 0);          send_packet(1'b0);
    build_v4(5, PROTO_UDP, 2, 0, 0);          send_packet(1'b0);
    build_v4(15, PROTO_UDP, 4, 0, 0);         send_packet(1'b0);
    build_v4(0, PROTO_TCP, 0, 0, 0);          send_packet(1'b0);
    build_v4(5, 255, 0, 0, 5);                send_packet(1'b0);
    build_v4(5, 0, 4, 6, 0);                  send_packet(1'b0);
    pkt.delete(); pkt.push_back(8'hff);       send_packet(1'b1);
    build_v6(all_ext, PROTO_TCP, 8, 0, 0);    send_packet(1'b1);
    ch = '{EXT_HOP};
    build_v6(ch, 44, 8, 0, 0);                send_packet(1'b1);
    build_v6(ch, PROTO_UDP, 0, 0, 0);         send_packet(1'b1);
    ch = '{EXT_AUTH, EXT_ROUTE};
    build_v6(ch, PROTO_UDP, 0, 0, 9);         send_packet(1'b1);
    ch.delete();
    build_v6(ch, 59, 0, 0, 0);                send_packet(1'b1);
    build_v6(ch, PROTO_TCP, 4, 3, 0);         send_packet(1'b1);
    build_v6(ch, PROTO_TCP, 0, 0, 30);        send_packet(1'b1);
  endtask

  initial begin
    int prefixes[$];
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // receiver held off while the first packets stream in without gaps
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    directed();

    prefixes = '{0, 63, 4, 1, 20, 7};
    foreach (prefixes[k]) begin
      write_prefix(prefixes[k]);
      gaps_on  = (k != 2);
      stall_on = (k != 3);
      for (int n = 0; n < 3; n++) begin
        if (n == 1) begin
          // pause until every result is back
          s_tvalid <= 1'b0;
          while (sb.pending_results.size() != 0) @(posedge clk);
        end
        random_packet();
      end
    end

    write_prefix($urandom_range(0, 63));
    gaps_on = 1'b0;
    stall_on = 1'b0;
    build_v4(5, PROTO_UDP, 4, 0, 0);
    send_packet(1'b0);

    s_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
